>>> rtl/core/lpmt_pkg.sv
// Shared types and constants of the IPv6 longest prefix match table.
`timescale 1ns / 1ps
package lpmt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } lpmt_cmd_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [7:0] PREFIX_MAX = 8'd128;

  localparam int unsigned IN_DATA_W   = 296;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 160;
  localparam int unsigned OUT_USER_W  = 2;

  typedef struct packed {
    logic        valid;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  len;
  } key_t;

  typedef struct packed {
    logic [31:0] iface;
    logic [63:0] hop_lo;
    logic [63:0] hop_hi;
  } route_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/ipv6_longest_prefix_match_table_unit.sv
// IPv6 longest prefix match routing table, top level.
//
// A routing table of TABLE_ENTRIES slots, each keyed by a 128-bit address and a prefix
// length. Every item (insert, delete or query, selected by s_axis_tuser) gives exactly one
// result. The block works on one item at a time: after reset a clearing pass writes every
// slot of the key memory with no item accepted; after that each item is scanned, one key
// slot per cycle from a single memory read port, with the masked compare run on each. A
// finished result waits in an output register, so the next item is accepted while it is
// still unclaimed; the scan of that item then holds at its end until the register is free.
// Equal-length matches go to the lowest slot; a /0 route matches any address.
`timescale 1ns / 1ps
module ipv6_longest_prefix_match_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // addr_hi[63:0], addr_lo[127:64], prefix_len[135:128], hop_hi[199:136],
  // hop_lo[263:200], iface[295:264]
  input  logic [lpmt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command[1:0]
  input  logic [lpmt_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_hop_hi[63:0], out_hop_lo[127:64], out_iface[159:128]
  output logic [lpmt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // found[0], status[1]
  output logic [lpmt_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import lpmt_pkg::*;

  ctrl_cmd_t dp_cmd;
  dp_sts_t   dp_sts;

  lpmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  lpmt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while the previous one is still in work");

  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.finish |=> m_axis_tvalid)
    else $error("finished item not presented on the output");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(dp_cmd.finish))
    else $error("output valid without a finished item");

  a_no_write_over_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !dp_cmd.finish)
    else $error("result register overwritten before it was taken");

endmodule

>>> rtl/core/lpmt_ram.sv
// Generic simple dual port RAM with registered read data.
`timescale 1ns / 1ps
module lpmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lpmt_ctrl.sv
// Sequencer of the table: clearing pass, item load, scan and result hand-off.
`timescale 1ns / 1ps
module lpmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpmt_pkg::dp_sts_t   sts_i,
  output lpmt_pkg::ctrl_cmd_t cmd_o
);
  import lpmt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } lpmt_state_e;

  lpmt_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/lpmt_dp.sv
// Datapath: item registers, slot scan with masked compare, table writes, result register.
`timescale 1ns / 1ps
module lpmt_dp #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpmt_pkg::ctrl_cmd_t                 cmd_i,
  output lpmt_pkg::dp_sts_t                   sts_o,
  input  logic [lpmt_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [lpmt_pkg::IN_USER_W-1:0]      in_user_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lpmt_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [lpmt_pkg::OUT_USER_W-1:0]     out_user_o
);
  import lpmt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(TABLE_ENTRIES);

  // item registers
  logic [1:0]   cmd_q;
  logic [127:0] addr_q;
  logic [7:0]   len_q;
  route_t       route_in_q;

  // scan registers
  logic [CNT_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             match_found_q, free_found_q, best_found_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q, best_idx_q;
  logic [7:0]       best_len_q;

  // result register
  logic             out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic [IDX_W-1:0] cnt_idx;
  logic             cnt_run;
  key_t             key_rdata;
  route_t           route_rdata;
  logic [127:0]     mask;
  logic             key_hit, lpm_hit;
  logic [7:0]       in_len, in_len_sat;

  logic             key_we, route_we;
  logic [IDX_W-1:0] key_waddr, ins_idx;
  key_t             key_wdata;
  logic             ins_ok, del_hit;
  logic             res_found, res_status;
  route_t           res_route;

  assign cnt_idx = cnt_q[IDX_W-1:0];
  assign cnt_run = (cnt_q < END_CNT);

  assign in_len     = in_data_i[135:128];
  assign in_len_sat = (in_len > PREFIX_MAX) ? PREFIX_MAX : in_len;

  assign mask    = ~({128{1'b1}} >> key_rdata.len);
  assign lpm_hit = key_rdata.valid &&
                   (((addr_q ^ {key_rdata.addr_hi, key_rdata.addr_lo}) & mask) == '0) &&
                   (!best_found_q || (key_rdata.len > best_len_q));
  assign key_hit = key_rdata.valid && (key_rdata.addr_hi == addr_q[127:64]) &&
                   (key_rdata.addr_lo == addr_q[63:0]) && (key_rdata.len == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        cnt_q         <= '0;
        rd_vld_q      <= 1'b0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        best_found_q  <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (cnt_run) begin
          cnt_q <= cnt_q + 1'b1;
        end
        rd_vld_q <= cnt_run;
        if (rd_vld_q) begin
          if (key_hit && !match_found_q) begin
            match_found_q <= 1'b1;
          end
          if (!key_rdata.valid && !free_found_q) begin
            free_found_q <= 1'b1;
          end
          if (lpm_hit) begin
            best_found_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= in_user_i;
      addr_q     <= {in_data_i[63:0], in_data_i[127:64]};
      len_q      <= in_len_sat;
      route_in_q <= '{hop_hi: in_data_i[199:136], hop_lo: in_data_i[263:200],
                      iface: in_data_i[295:264]};
    end
    if (cmd_i.scan) begin
      rd_idx_q <= cnt_idx;
      if (rd_vld_q) begin
        if (key_hit && !match_found_q) begin
          match_idx_q <= rd_idx_q;
        end
        if (!key_rdata.valid && !free_found_q) begin
          free_idx_q <= rd_idx_q;
        end
        if (lpm_hit) begin
          best_idx_q <= rd_idx_q;
          best_len_q <= key_rdata.len;
        end
      end
    end
  end

  assign ins_ok  = (cmd_q == CMD_INSERT) && (match_found_q || free_found_q);
  assign del_hit = (cmd_q == CMD_DELETE) && match_found_q;
  assign ins_idx = match_found_q ? match_idx_q : free_idx_q;

  always_comb begin
    key_we    = 1'b0;
    key_waddr = ins_idx;
    key_wdata = '{valid: (cmd_q == CMD_INSERT), addr_hi: addr_q[127:64],
                  addr_lo: addr_q[63:0], len: len_q};
    if (cmd_i.clear) begin
      key_we    = 1'b1;
      key_waddr = cnt_idx;
      key_wdata = '0;
    end else if (cmd_i.finish && (ins_ok || del_hit)) begin
      key_we    = 1'b1;
      key_waddr = del_hit ? match_idx_q : ins_idx;
    end
  end

  assign route_we = cmd_i.finish && ins_ok;

  lpmt_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (cnt_idx),
    .rdata_o (key_rdata)
  );

  lpmt_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .waddr_i (ins_idx),
    .wdata_i (route_in_q),
    .raddr_i (best_idx_q),
    .rdata_o (route_rdata)
  );

  always_comb begin
    res_found  = 1'b0;
    res_status = STATUS_OK;
    res_route  = '0;
    case (cmd_q)
      CMD_INSERT: begin
        res_status = (match_found_q || free_found_q) ? STATUS_OK : STATUS_FULL;
      end
      CMD_QUERY: begin
        res_found = best_found_q;
        if (best_found_q) begin
          res_route = route_rdata;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {res_route.iface, res_route.hop_lo, res_route.hop_hi};
      out_user_q <= {res_status, res_found};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  assign sts_o.clear_last = (cnt_q == LAST_CNT);
  assign sts_o.scan_done  = !cnt_run && !rd_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule
